/* hdl/tpbi_pkg.sv */
// ----------------------------------------------------------------------------
// Timed pose buffer package
// Shared constants, entry layout, sequencer states and the ring slot helper.
// ----------------------------------------------------------------------------
package tpbi_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [31:0] RETENTION_RESET = 32'd1000000;

   localparam logic [2:0] ST_READY    = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_TOO_OLD  = 3'd2;
   localparam logic [2:0] ST_FUTURE   = 3'd3;
   localparam logic [2:0] ST_CLOCK    = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;

   localparam logic MODE_PUSH = 1'b0;

   localparam logic [1:0] OP_X       = 2'd0;
   localparam logic [1:0] OP_Y       = 2'd1;
   localparam logic [1:0] OP_HEADING = 2'd2;

   typedef struct packed {
      logic [31:0] stamp;
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] heading;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [31:0] mag;
      logic [31:0] t;
      logic [31:0] d;
   } scale_cmd_type;

   typedef enum logic [4:0] {
      S_IDLE, S_PUSH_RD, S_PUSH_CHK, S_PUSH_WR, S_PRUNE_RD, S_PRUNE_CHK,
      S_OLD_RD, S_OLD_CHK, S_NEW_RD, S_NEW_CHK, S_SRCH_RD, S_SRCH_CHK,
      S_HI_RD, S_HI_CHK, S_LO_RD, S_LO_CHK, S_SCALE, S_WAIT, S_DONE
   } state_type;

   typedef enum logic [1:0] {SC_IDLE, SC_MUL, SC_ADD, SC_DIV} scale_state_type;

   function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] oldest,
                                              input logic [CNT_W-1:0]  k);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, oldest} + {1'b0, k};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

/* hdl/tpbi_scale_unit.sv */
// ----------------------------------------------------------------------------
// Scale unit
// Computes round(mag * t / d) for t < d: one multiply, one rounding add, then
// a restoring divide that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpbi_scale_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  tpbi_pkg::scale_cmd_type cmd,
   output logic                   done,
   output logic [31:0]            quotient
);

   tpbi_pkg::scale_state_type state_ff, state_in;
   logic [31:0] a_ff, b_ff, d_ff;
   logic [63:0] prod_ff;
   logic [31:0] rem_ff, low_ff;
   logic [5:0]  cnt_ff;
   logic        done_ff;
   logic [64:0] num;
   logic [32:0] trial;
   logic        qbit;

   assign num   = {1'b0, prod_ff} + {33'd0, 1'b0, d_ff[31:1]};
   assign trial = {rem_ff, low_ff[31]};
   assign qbit  = trial >= {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpbi_pkg::SC_IDLE: begin
            if (cmd.start) state_in = tpbi_pkg::SC_MUL;
         end
         tpbi_pkg::SC_MUL: state_in = tpbi_pkg::SC_ADD;
         tpbi_pkg::SC_ADD: state_in = tpbi_pkg::SC_DIV;
         tpbi_pkg::SC_DIV: begin
            if (cnt_ff == 6'd1) state_in = tpbi_pkg::SC_IDLE;
         end
         default: state_in = tpbi_pkg::SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpbi_pkg::SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == tpbi_pkg::SC_DIV) && (cnt_ff == 6'd1);
      end
      unique case (state_ff)
         tpbi_pkg::SC_IDLE: begin
            a_ff <= cmd.mag;
            b_ff <= cmd.t;
            d_ff <= cmd.d;
         end
         tpbi_pkg::SC_MUL: prod_ff <= a_ff * b_ff;
         tpbi_pkg::SC_ADD: begin
            rem_ff <= num[63:32];
            low_ff <= num[31:0];
            cnt_ff <= 6'd32;
         end
         tpbi_pkg::SC_DIV: begin
            rem_ff <= qbit ? 32'(trial - {1'b0, d_ff}) : trial[31:0];
            low_ff <= {low_ff[30:0], qbit};
            cnt_ff <= cnt_ff - 6'd1;
         end
         default: ;
      endcase
   end

   assign done     = done_ff;
   assign quotient = low_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == tpbi_pkg::SC_IDLE)
      else $error("scale start while unit is running");
   a_done_after_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == tpbi_pkg::SC_DIV)
      else $error("scale done without a divide step");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == tpbi_pkg::SC_DIV |-> rem_ff < d_ff)
      else $error("divide remainder out of range");

endmodule

/* hdl/timed_pose_buffer_interpolator.sv */
// ----------------------------------------------------------------------------
// Timed pose buffer interpolator
// Ring of time-ordered poses with pruning and interpolated queries.
// ----------------------------------------------------------------------------
// A push checks the newest stamp unless empty, writes if newer, then prunes
// expired entries; a query checks oldest and newest stamps, binary searches,
// reads the upper and, to interpolate, lower entry, then divides per field.
// One transaction at a time; busy stays high until the result.
// Reset clears the ring to empty and the retention window to 1000000 ticks.
// The receiver cannot stall: each result is shown for exactly one cycle.
module timed_pose_buffer_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [31:0] req_stamp,
   input  logic signed [31:0] req_x_position,
   input  logic signed [31:0] req_y_position,
   input  logic signed [15:0] req_heading,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [15:0] rsp_out_heading
);

   localparam int AW = tpbi_pkg::ADDR_W;
   localparam int CW = tpbi_pkg::CNT_W;

   tpbi_pkg::state_type state_ff, state_in;
   tpbi_pkg::entry_type mem [tpbi_pkg::DEPTH];
   tpbi_pkg::entry_type mem_q, hi_ent_ff, lo_ent_ff, wr_ent;
   logic [AW-1:0] rd_addr, wr_addr, oldest_ff;
   logic          wr_en;
   logic [CW-1:0] count_ff, lo_ff, hi_ff, mid;
   logic [CW:0]   mid_sum;
   logic [31:0]   retention_ff, stamp_ff, x_ff, y_ff, t_ff, d_ff;
   logic [15:0]   heading_ff;
   logic          mode_ff, neg_ff;
   logic [1:0]    op_ff;
   logic [2:0]    status_ff;
   logic [31:0]   ox_ff, oy_ff;
   logic [15:0]   oh_ff;
   logic          full;
   logic          prune_hit;
   logic [32:0]   delta, dmag;
   logic [15:0]   dh;
   logic [16:0]   hmag;
   logic          neg;
   logic [31:0]   mag, offset;
   tpbi_pkg::scale_cmd_type scale_cmd;
   logic          scale_done;
   logic [31:0]   scale_q;

   assign full      = count_ff == CW'(tpbi_pkg::DEPTH);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CW:1];
   assign prune_hit = ({1'b0, mem_q.stamp} + {1'b0, retention_ff}) < {1'b0, stamp_ff};

   always_comb begin
      unique case (op_ff)
         tpbi_pkg::OP_X: delta = {hi_ent_ff.x[31], hi_ent_ff.x} - {lo_ent_ff.x[31], lo_ent_ff.x};
         tpbi_pkg::OP_Y: delta = {hi_ent_ff.y[31], hi_ent_ff.y} - {lo_ent_ff.y[31], lo_ent_ff.y};
         default: delta = 33'd0;
      endcase
   end
   assign dmag = delta[32] ? 33'(-delta) : delta;
   assign dh   = hi_ent_ff.heading - lo_ent_ff.heading;
   assign hmag = dh[15] ? 17'(-{1'b1, dh}) : {1'b0, dh};
   assign neg  = (op_ff == tpbi_pkg::OP_HEADING) ? dh[15] : delta[32];
   assign mag  = (op_ff == tpbi_pkg::OP_HEADING) ? {15'd0, hmag} : dmag[31:0];
   assign offset = neg_ff ? 32'(-scale_q) : scale_q;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_ent;
      mem_q <= mem[rd_addr];
   end

   tpbi_scale_unit u_scale (
      .clock    (clock),
      .reset    (reset),
      .cmd      (scale_cmd),
      .done     (scale_done),
      .quotient (scale_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpbi_pkg::S_IDLE: begin
            if (start) begin
               if (req_mode == tpbi_pkg::MODE_PUSH) begin
                  state_in = (count_ff == '0) ? tpbi_pkg::S_PUSH_WR : tpbi_pkg::S_PUSH_RD;
               end else begin
                  state_in = (count_ff == '0) ? tpbi_pkg::S_DONE : tpbi_pkg::S_OLD_RD;
               end
            end
         end
         tpbi_pkg::S_PUSH_RD:  state_in = tpbi_pkg::S_PUSH_CHK;
         tpbi_pkg::S_PUSH_CHK: state_in = (stamp_ff <= mem_q.stamp) ?
                                          tpbi_pkg::S_DONE : tpbi_pkg::S_PUSH_WR;
         tpbi_pkg::S_PUSH_WR:  state_in = tpbi_pkg::S_PRUNE_RD;
         tpbi_pkg::S_PRUNE_RD: state_in = (count_ff > CW'(2)) ?
                                          tpbi_pkg::S_PRUNE_CHK : tpbi_pkg::S_DONE;
         tpbi_pkg::S_PRUNE_CHK: state_in = prune_hit ? tpbi_pkg::S_PRUNE_RD : tpbi_pkg::S_DONE;
         tpbi_pkg::S_OLD_RD:   state_in = tpbi_pkg::S_OLD_CHK;
         tpbi_pkg::S_OLD_CHK:  state_in = (stamp_ff < mem_q.stamp) ?
                                          tpbi_pkg::S_DONE : tpbi_pkg::S_NEW_RD;
         tpbi_pkg::S_NEW_RD:   state_in = tpbi_pkg::S_NEW_CHK;
         tpbi_pkg::S_NEW_CHK:  state_in = (stamp_ff > mem_q.stamp) ?
                                          tpbi_pkg::S_DONE : tpbi_pkg::S_SRCH_RD;
         tpbi_pkg::S_SRCH_RD:  state_in = (lo_ff < hi_ff) ? tpbi_pkg::S_SRCH_CHK : tpbi_pkg::S_HI_RD;
         tpbi_pkg::S_SRCH_CHK: state_in = tpbi_pkg::S_SRCH_RD;
         tpbi_pkg::S_HI_RD:    state_in = tpbi_pkg::S_HI_CHK;
         tpbi_pkg::S_HI_CHK:   state_in = ((hi_ff == '0) || (mem_q.stamp == stamp_ff)) ?
                                          tpbi_pkg::S_DONE : tpbi_pkg::S_LO_RD;
         tpbi_pkg::S_LO_RD:    state_in = tpbi_pkg::S_LO_CHK;
         tpbi_pkg::S_LO_CHK:   state_in = tpbi_pkg::S_SCALE;
         tpbi_pkg::S_SCALE:    state_in = tpbi_pkg::S_WAIT;
         tpbi_pkg::S_WAIT: begin
            if (scale_done) begin
               state_in = (op_ff == tpbi_pkg::OP_HEADING) ? tpbi_pkg::S_DONE : tpbi_pkg::S_SCALE;
            end
         end
         tpbi_pkg::S_DONE:     state_in = tpbi_pkg::S_IDLE;
         default:              state_in = tpbi_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      rd_addr         = tpbi_pkg::slot(oldest_ff, CW'(0));
      wr_en           = 1'b0;
      wr_addr         = full ? oldest_ff : tpbi_pkg::slot(oldest_ff, count_ff);
      wr_ent.stamp    = stamp_ff;
      wr_ent.x        = x_ff;
      wr_ent.y        = y_ff;
      wr_ent.heading  = heading_ff;
      scale_cmd.start = 1'b0;
      scale_cmd.mag   = mag;
      scale_cmd.t     = t_ff;
      scale_cmd.d     = d_ff;
      unique case (state_ff)
         tpbi_pkg::S_PUSH_RD,
         tpbi_pkg::S_NEW_RD:   rd_addr = tpbi_pkg::slot(oldest_ff, count_ff - CW'(1));
         tpbi_pkg::S_PRUNE_RD: rd_addr = tpbi_pkg::slot(oldest_ff, CW'(1));
         tpbi_pkg::S_SRCH_RD:  rd_addr = tpbi_pkg::slot(oldest_ff, mid);
         tpbi_pkg::S_HI_RD:    rd_addr = tpbi_pkg::slot(oldest_ff, hi_ff);
         tpbi_pkg::S_LO_RD:    rd_addr = tpbi_pkg::slot(oldest_ff, hi_ff - CW'(1));
         tpbi_pkg::S_PUSH_WR:  wr_en = 1'b1;
         tpbi_pkg::S_SCALE:    scale_cmd.start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpbi_pkg::S_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         retention_ff <= tpbi_pkg::RETENTION_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) retention_ff <= csr_wr_data;
         if (state_ff == tpbi_pkg::S_PUSH_WR) begin
            if (full) begin
               oldest_ff <= tpbi_pkg::slot(oldest_ff, CW'(1));
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if ((state_ff == tpbi_pkg::S_PRUNE_CHK) && prune_hit) begin
            oldest_ff <= tpbi_pkg::slot(oldest_ff, CW'(1));
            count_ff  <= count_ff - CW'(1);
         end
      end
      unique case (state_ff)
         tpbi_pkg::S_IDLE: begin
            mode_ff    <= req_mode;
            stamp_ff   <= req_stamp;
            x_ff       <= req_x_position;
            y_ff       <= req_y_position;
            heading_ff <= req_heading;
            status_ff  <= (req_mode != tpbi_pkg::MODE_PUSH && count_ff == '0) ?
                          tpbi_pkg::ST_EMPTY : tpbi_pkg::ST_READY;
            ox_ff      <= '0;
            oy_ff      <= '0;
            oh_ff      <= '0;
         end
         tpbi_pkg::S_PUSH_CHK: begin
            if (stamp_ff <= mem_q.stamp) status_ff <= tpbi_pkg::ST_CLOCK;
         end
         tpbi_pkg::S_PUSH_WR: begin
            if (full) status_ff <= tpbi_pkg::ST_OVERFLOW;
         end
         tpbi_pkg::S_OLD_CHK: begin
            if (stamp_ff < mem_q.stamp) status_ff <= tpbi_pkg::ST_TOO_OLD;
         end
         tpbi_pkg::S_NEW_CHK: begin
            if (stamp_ff > mem_q.stamp) status_ff <= tpbi_pkg::ST_FUTURE;
            lo_ff <= '0;
            hi_ff <= count_ff - CW'(1);
         end
         tpbi_pkg::S_SRCH_CHK: begin
            if (mem_q.stamp >= stamp_ff) begin
               hi_ff <= mid;
            end else begin
               lo_ff <= mid + CW'(1);
            end
         end
         tpbi_pkg::S_HI_CHK: begin
            hi_ent_ff <= mem_q;
            if ((hi_ff == '0) || (mem_q.stamp == stamp_ff)) begin
               ox_ff <= mem_q.x;
               oy_ff <= mem_q.y;
               oh_ff <= mem_q.heading;
            end
         end
         tpbi_pkg::S_LO_CHK: begin
            lo_ent_ff <= mem_q;
            t_ff      <= stamp_ff - mem_q.stamp;
            d_ff      <= hi_ent_ff.stamp - mem_q.stamp;
            op_ff     <= tpbi_pkg::OP_X;
         end
         tpbi_pkg::S_SCALE: neg_ff <= neg;
         tpbi_pkg::S_WAIT: begin
            if (scale_done) begin
               op_ff <= op_ff + 2'd1;
               unique case (op_ff)
                  tpbi_pkg::OP_X: ox_ff <= lo_ent_ff.x + offset;
                  tpbi_pkg::OP_Y: oy_ff <= lo_ent_ff.y + offset;
                  default:        oh_ff <= lo_ent_ff.heading + offset[15:0];
               endcase
            end
         end
         default: ;
      endcase
   end

   assign busy            = state_ff != tpbi_pkg::S_IDLE;
   assign rsp_valid       = state_ff == tpbi_pkg::S_DONE;
   assign rsp_status      = status_ff;
   assign rsp_out_x       = ox_ff;
   assign rsp_out_y       = oy_ff;
   assign rsp_out_heading = oh_ff;

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("result strobe not followed by idle");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(tpbi_pkg::DEPTH))
      else $error("entry count beyond ring depth");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == tpbi_pkg::S_SRCH_RD |-> lo_ff <= hi_ff)
      else $error("search bounds crossed");
   a_mode_query: assert property (@(posedge clock) disable iff (reset)
      state_ff == tpbi_pkg::S_SCALE |-> mode_ff != tpbi_pkg::MODE_PUSH)
      else $error("interpolation during a push");

endmodule
